[rtl/ptt_pkg.sv]
// shared types and constants for the periodic timer table
package ptt_pkg;

  localparam int unsigned SLOTS_DEFAULT = 32;
  localparam logic [15:0] CAP_RESET     = 16'd1000;
  localparam int unsigned TICK_W        = 48;
  localparam int unsigned SLOT_OUT_W    = 5;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_CLR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_ADD_ACK   = 3'd0,
    KIND_DEL_ACK   = 3'd1,
    KIND_CLR_ACK   = 3'd2,
    KIND_DUE       = 3'd3,
    KIND_TICK_DONE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_DRAIN,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] period;
    logic [15:0] del_id;
    logic [15:0] client_tag;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic        status;
    logic [15:0] assigned_id;
    logic [4:0]  slot_index;
    logic [15:0] tag_out;
    logic [15:0] next_wait;
    logic        last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic now_inc;
    logic add_try;
    logic walk_issue;
    logic clear_all;
    logic emit_final;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic idx_last;
    logic pipe_busy;
  } sts_t;

endpackage

[rtl/ptt_ctrl.sv]
// sequencing state machine of the periodic timer table
module ptt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ptt_pkg::mode_e mode_i,
  input  ptt_pkg::sts_t  sts_i,
  output ptt_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import ptt_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          unique case (mode_i)
            MODE_TICK: begin
              cmd_o.now_inc = 1'b1;
              state_d       = ST_WALK;
            end
            MODE_ADD: state_d = ST_ADD;
            MODE_DEL: state_d = ST_WALK;
            MODE_CLR: state_d = ST_CLEAR;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        cmd_o.add_try = 1'b1;
        if (sts_i.slot_free || sts_i.idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd_o.walk_issue = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.emit_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_all = 1'b1;
        state_d         = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[rtl/ptt_dp.sv]
// slot storage, tick counter, slot walk pipeline and result register
module ptt_dp #(
  parameter int unsigned Slots = ptt_pkg::SLOTS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptt_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  ptt_pkg::cmd_t    cmd_i,
  output ptt_pkg::sts_t    sts_o,
  output logic             res_strobe_o,
  output ptt_pkg::result_t result_o
);
  import ptt_pkg::*;

  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;

  // slot memories, used bits and counters
  logic [15:0]       id_mem  [Slots];
  logic [15:0]       per_mem [Slots];
  logic [TICK_W-1:0] dl_mem  [Slots];
  logic [15:0]       tag_mem [Slots];

  logic [Slots-1:0]  used_q;
  logic [TICK_W-1:0] now_q;
  logic [15:0]       next_id_q;
  logic [15:0]       cap_q;
  logic [SlotW-1:0]  idx_q;
  item_t             op_q;

  // walk pipeline
  logic              p1_vld_q, p2_vld_q;
  logic [SlotW-1:0]  p1_idx_q;
  logic              used_rd_q;
  logic [15:0]       id_rd_q, per_rd_q, tag_rd_q;
  logic [TICK_W-1:0] dl_rd_q;
  logic              p2_used_q;
  logic [TICK_W-1:0] p2_nd_q;
  logic [15:0]       wait_q;

  logic              res_strobe_q;
  result_t           res_q;

  logic              is_tick, slot_free, add_we, p1_due, del_hit, dl_we, new_min;
  logic [TICK_W-1:0] p1_nd, add_dl, dl_wdata, d_val;
  logic [TICK_W:0]   diff;
  logic [SlotW-1:0]  dl_waddr;
  logic [SlotW+SLOT_OUT_W-1:0] idx_ext, p1_idx_ext;
  logic [15:0]       id_inc;
  logic              res_strobe_d;
  result_t           res_d;

  // slot evaluation
  always_comb begin
    is_tick    = (op_q.mode == MODE_TICK);
    slot_free  = !used_q[idx_q];
    add_we     = cmd_i.add_try && slot_free;
    add_dl     = now_q + {{(TICK_W-16){1'b0}}, op_q.period};
    p1_due     = used_rd_q && (dl_rd_q <= now_q);
    p1_nd      = p1_due ? (now_q + {{(TICK_W-16){1'b0}}, per_rd_q}) : dl_rd_q;
    del_hit    = used_rd_q && (id_rd_q == op_q.del_id);
    diff       = {1'b0, p2_nd_q} - {1'b0, now_q};
    d_val      = diff[TICK_W] ? '0 : diff[TICK_W-1:0];
    new_min    = p2_vld_q && p2_used_q && (d_val < {{(TICK_W-16){1'b0}}, wait_q});
    dl_we      = add_we || (p1_vld_q && is_tick && p1_due);
    dl_waddr   = cmd_i.add_try ? idx_q : p1_idx_q;
    dl_wdata   = cmd_i.add_try ? add_dl : p1_nd;
    idx_ext    = {{SLOT_OUT_W{1'b0}}, idx_q};
    p1_idx_ext = {{SLOT_OUT_W{1'b0}}, p1_idx_q};
    id_inc     = (next_id_q == 16'hFFFF) ? 16'd1 : (next_id_q + 16'd1);
  end

  assign sts_o.slot_free = slot_free;
  assign sts_o.idx_last  = (idx_q == SlotW'(Slots - 1));
  assign sts_o.pipe_busy = p1_vld_q || p2_vld_q;

  // slot memories: written on add and on reload, read during the walk
  always_ff @(posedge clk_i) begin
    if (add_we) begin
      id_mem[idx_q]  <= next_id_q;
      per_mem[idx_q] <= op_q.period;
      tag_mem[idx_q] <= op_q.client_tag;
    end
    if (dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    if (cmd_i.walk_issue) begin
      id_rd_q  <= id_mem[idx_q];
      per_rd_q <= per_mem[idx_q];
      dl_rd_q  <= dl_mem[idx_q];
      tag_rd_q <= tag_mem[idx_q];
    end
  end

  // control state: used bits, counters, pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      now_q        <= '0;
      next_id_q    <= 16'd1;
      cap_q        <= CAP_RESET;
      idx_q        <= '0;
      p1_vld_q     <= 1'b0;
      p2_vld_q     <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.now_inc) begin
        now_q <= now_q + TICK_W'(1);
      end
      if (cmd_i.accept) begin
        idx_q <= '0;
      end else if ((cmd_i.add_try && !slot_free) || cmd_i.walk_issue) begin
        idx_q <= idx_q + SlotW'(1);
      end
      if (add_we) begin
        next_id_q <= id_inc;
      end
      priority if (cmd_i.clear_all) begin
        used_q <= '0;
      end else if (add_we) begin
        used_q[idx_q] <= 1'b1;
      end else if (p1_vld_q && !is_tick && del_hit) begin
        used_q[p1_idx_q] <= 1'b0;
      end
      p1_vld_q     <= cmd_i.walk_issue;
      p2_vld_q     <= p1_vld_q;
      res_strobe_q <= res_strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= item_i;
    end
    if (cmd_i.walk_issue) begin
      p1_idx_q  <= idx_q;
      used_rd_q <= used_q[idx_q];
    end
    p2_nd_q   <= p1_nd;
    p2_used_q <= used_rd_q;
    if (cmd_i.accept) begin
      wait_q <= cap_q;
    end else if (new_min) begin
      wait_q <= d_val[15:0];
    end
    res_q <= res_d;
  end

  // result selection
  always_comb begin
    res_strobe_d = 1'b0;
    res_d        = '0;
    if (cmd_i.add_try && (slot_free || sts_o.idx_last)) begin
      res_strobe_d = 1'b1;
      res_d.kind   = KIND_ADD_ACK;
      res_d.last   = 1'b1;
      if (slot_free) begin
        res_d.assigned_id = next_id_q;
        res_d.slot_index  = idx_ext[SLOT_OUT_W-1:0];
      end else begin
        res_d.status = STATUS_FULL;
      end
    end else if (cmd_i.clear_all) begin
      res_strobe_d = 1'b1;
      res_d.kind   = KIND_CLR_ACK;
      res_d.last   = 1'b1;
    end else if (cmd_i.emit_final) begin
      res_strobe_d = 1'b1;
      res_d.last   = 1'b1;
      if (is_tick) begin
        res_d.kind      = KIND_TICK_DONE;
        res_d.next_wait = wait_q;
      end else begin
        res_d.kind = KIND_DEL_ACK;
      end
    end else if (p1_vld_q && is_tick && p1_due) begin
      res_strobe_d      = 1'b1;
      res_d.kind        = KIND_DUE;
      res_d.assigned_id = id_rd_q;
      res_d.slot_index  = p1_idx_ext[SLOT_OUT_W-1:0];
      res_d.tag_out     = tag_rd_q;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign result_o     = res_q;

endmodule

[rtl/periodic_timer_table.sv]
// top level of the periodic timer table
//
// An item is taken at a rising edge with start high and busy low; busy stays
// high until the item's last result has been loaded into the result register.
// Each result shows on result_o for one cycle with res_strobe_o high; the
// receiver cannot stall, so it must take every strobed result. The final
// result of an item carries last = 1.
// Behaviour after the transfer edge:
//   clear: passes through the clear state, which empties the table and loads the ack; busy only in that state
//   add:   scans the used bits one slot per cycle, busy until a free slot or the last slot is reached
//   delete and tick: walk every slot through a three stage read / evaluate /
//          minimum pipeline at one slot per cycle, busy until the walk and the pipeline
//          have drained; due reports stream out as the walk reaches them
// The slot walk over the single read port of the slot memories sets the rate.
// The idle wait cap is to be written through cfg_we_i / cfg_wdata_i only while idle; the block does not enforce this.
// Reset empties the table, sets the tick count to 0, the next id to 1 and the
// wait cap to 1000; slot contents are undefined until a slot is filled.
module periodic_timer_table #(
  parameter int unsigned Slots = ptt_pkg::SLOTS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ptt_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  output logic             res_strobe_o,
  output ptt_pkg::result_t result_o
);
  import ptt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  ptt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (item_i.mode),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // storage and walk datapath
  ptt_dp #(
    .Slots(Slots)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_strobe_o(res_strobe_o),
    .result_o    (result_o)
  );

endmodule

[verif/tb_top.sv]
// testbench for the periodic timer table: directed and random command traffic checked per result
module tb_top;
  import ptt_pkg::*;

  localparam int unsigned NumSlots   = SLOTS_DEFAULT;
  localparam int unsigned PhaseItems = 45;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  item_t       item_i      = '0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        res_strobe_o;
  result_t     result_o;

  // commands waiting to be sent and reports still owed by the block
  item_t       cmd_backlog[$];
  result_t     report_queue[$];
  int unsigned bad_reports = 0;
  int unsigned gap_left    = 0;
  logic        steady      = 1'b0;

  // timer table image kept alongside the block
  logic        tmr_used     [NumSlots];
  logic [15:0] tmr_id       [NumSlots];
  logic [15:0] tmr_period   [NumSlots];
  logic [47:0] tmr_deadline [NumSlots];
  logic [15:0] tmr_tag      [NumSlots];
  logic [15:0] id_next   = 16'd1;
  logic [47:0] now_ticks = '0;
  logic [15:0] wait_cap  = CAP_RESET;

  periodic_timer_table DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_strobe_o (res_strobe_o),
    .result_o     (result_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    foreach (tmr_used[i]) tmr_used[i] = 1'b0;
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // short periods fire often, long ones keep deadlines far out
  function automatic logic [15:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 8));
    if (r < 90) return 16'($urandom_range(9, 300));
    return rnd16();
  endfunction

  function automatic void queue_cmd(mode_e m, logic [15:0] per, logic [15:0] tid,
                                    logic [15:0] tag);
    item_t it;
    it.mode       = m;
    it.period     = per;
    it.del_id     = tid;
    it.client_tag = tag;
    cmd_backlog.push_back(it);
  endfunction

  // expected reports of one accepted command, state updated in place
  function automatic void table_step(item_t it);
    result_t     outs[$];
    result_t     r;
    int          found;
    logic [47:0] remain;
    logic [47:0] best;
    found = -1;
    r     = '0;
    case (it.mode)
      MODE_ADD: begin
        for (int i = 0; i < NumSlots; i++)
          if (!tmr_used[i] && found < 0) found = i;
        r.kind = KIND_ADD_ACK;
        if (found < 0) begin
          r.status = STATUS_FULL;
        end else begin
          tmr_used[found]     = 1'b1;
          tmr_id[found]       = id_next;
          tmr_period[found]   = it.period;
          tmr_deadline[found] = now_ticks + {32'd0, it.period};
          tmr_tag[found]      = it.client_tag;
          r.status            = STATUS_OK;
          r.assigned_id       = id_next;
          r.slot_index        = 5'(found);
          id_next             = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
        end
        outs.push_back(r);
      end
      MODE_DEL: begin
        for (int i = 0; i < NumSlots; i++)
          if (tmr_used[i] && tmr_id[i] == it.del_id) tmr_used[i] = 1'b0;
        r.kind = KIND_DEL_ACK;
        outs.push_back(r);
      end
      MODE_CLR: begin
        foreach (tmr_used[i]) tmr_used[i] = 1'b0;
        r.kind = KIND_CLR_ACK;
        outs.push_back(r);
      end
      default: begin
        now_ticks = now_ticks + 48'd1;
        best      = {32'd0, wait_cap};
        for (int i = 0; i < NumSlots; i++) begin
          if (tmr_used[i]) begin
            if (tmr_deadline[i] <= now_ticks) begin
              r             = '0;
              r.kind        = KIND_DUE;
              r.assigned_id = tmr_id[i];
              r.slot_index  = 5'(i);
              r.tag_out     = tmr_tag[i];
              outs.push_back(r);
              tmr_deadline[i] = now_ticks + {32'd0, tmr_period[i]};
            end
            remain = (tmr_deadline[i] >= now_ticks) ? tmr_deadline[i] - now_ticks : 48'd0;
            if (remain < best) best = remain;
          end
        end
        r           = '0;
        r.kind      = KIND_TICK_DONE;
        r.next_wait = best[15:0];
        outs.push_back(r);
      end
    endcase
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[k]) report_queue.push_back(outs[k]);
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      bad_reports++;
    end
  endfunction

  // driver: next command goes out once the current transfer is done and the gap has run out
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        item_i   <= cmd_backlog.pop_front();
        start    <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on each command transfer, compare each strobed report
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (start === 1'b1 && busy === 1'b0) table_step(item_i);
      if (res_strobe_o === 1'b1) begin
        if (report_queue.size() == 0) begin
          $error("unexpected report: kind %0d id %0d", result_o.kind, result_o.assigned_id);
          bad_reports++;
        end else begin
          want = report_queue.pop_front();
          check_field("kind", 16'(want.kind), 16'(result_o.kind));
          check_field("status", 16'(want.status), 16'(result_o.status));
          check_field("assigned_id", want.assigned_id, result_o.assigned_id);
          check_field("slot_index", 16'(want.slot_index), 16'(result_o.slot_index));
          check_field("tag_out", want.tag_out, result_o.tag_out);
          check_field("next_wait", want.next_wait, result_o.next_wait);
          check_field("last", 16'(want.last), 16'(result_o.last));
        end
      end
    end
  end

  // wait until every command is sent and every report is in
  task automatic settle_table();
    while (cmd_backlog.size() != 0 || start || report_queue.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_wait_cap(logic [15:0] v);
    settle_table();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    wait_cap     = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase_cnt;
    int unsigned r;
    logic [15:0] caps [5];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, period extremes, tag extremes, unknown deletes
    queue_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
    queue_cmd(MODE_DEL, 16'd0, 16'd0, 16'd0);
    queue_cmd(MODE_ADD, 16'd0, 16'd0, 16'hFFFF);
    queue_cmd(MODE_ADD, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_cmd(MODE_ADD, 16'd3, 16'd0, 16'hA5A5);
    queue_cmd(MODE_ADD, 16'd1, 16'd0, 16'h5A5A);
    repeat (5) queue_cmd(MODE_TICK, 16'd0, 16'd0, 16'd0);
    queue_cmd(MODE_DEL, 16'd0, 16'd1, 16'd0);
    queue_cmd(MODE_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(MODE_DEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(MODE_DEL, 16'd0, 16'd3, 16'd0);
    queue_cmd(MODE_TICK, 16'd0, 16'd0, 16'd0);
    queue_cmd(MODE_CLR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(MODE_TICK, 16'd0, 16'd0, 16'd0);
    queue_cmd(MODE_ADD, 16'd2, 16'd0, 16'h1234);
    repeat (3) queue_cmd(MODE_TICK, 16'd0, 16'd0, 16'd0);
    queue_cmd(MODE_CLR, 16'd0, 16'd0, 16'd0);

    // random phases, one wait cap each
    caps = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 40)),
             16'($urandom_range(1, 65535))};
    foreach (caps[p]) begin
      write_wait_cap(caps[p]);
      phase_cnt = 0;
      while (phase_cnt < PhaseItems) begin
        while (cmd_backlog.size() != 0) @(negedge clk_i);
        steady = ($urandom_range(0, 4) == 0);
        r      = $urandom_range(0, 99);
        if ((p == 0 && phase_cnt == 0) || r < 8) begin
          // fill the table past full with fast timers, then tick one to three times
          repeat (NumSlots + 2) queue_cmd(MODE_ADD, 16'($urandom_range(0, 3)), rnd16(), rnd16());
          repeat ($urandom_range(1, 3)) queue_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
          if ($urandom_range(0, 1) == 1) queue_cmd(MODE_CLR, rnd16(), rnd16(), rnd16());
        end else if (r < 60) begin
          repeat ($urandom_range(1, 3)) queue_cmd(MODE_ADD, pick_period(), rnd16(), rnd16());
          repeat ($urandom_range(2, 6)) queue_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
        end else if (r < 78) begin
          // mostly recent ids, sometimes any id
          if ($urandom_range(0, 4) == 0)
            queue_cmd(MODE_DEL, rnd16(), rnd16(), rnd16());
          else
            queue_cmd(MODE_DEL, rnd16(), id_next - 16'($urandom_range(1, 6)), rnd16());
          if ($urandom_range(0, 1) == 1) queue_cmd(MODE_TICK, rnd16(), rnd16(), rnd16());
        end else if (r < 85) begin
          queue_cmd(MODE_CLR, rnd16(), rnd16(), rnd16());
        end else begin
          repeat ($urandom_range(1, 4))
            queue_cmd(mode_e'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16());
        end
        phase_cnt += cmd_backlog.size();
      end
    end

    // drain and let the block go quiet
    while (cmd_backlog.size() != 0 || start) @(negedge clk_i);
    for (int k = 0; k < 2000 && report_queue.size() != 0; k++) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (report_queue.size() != 0) begin
      $error("%0d expected reports never arrived", report_queue.size());
      bad_reports++;
    end
    if (bad_reports == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
